// ----- rtl/core/b64e_pkg.sv -----
// shared types, constants and the symbol lookup for the base64 stream encoder
// no dependencies; used by every module of the encoder
package b64e_pkg;

	// configuration register indexes
	localparam int CfgIdxW = 1;
	localparam logic [CfgIdxW-1:0] RegWrapEnable = 1'd0;
	localparam logic [CfgIdxW-1:0] RegLineGroups = 1'd1;

	localparam int CfgDataW   = 6;
	localparam int LineCountW = 6;

	// reset values of the configuration registers
	localparam logic                  WrapEnableRst = 1'b1;
	localparam logic [LineCountW-1:0] LineGroupsRst = 6'd19;

	// special characters
	localparam logic [6:0] CharCr  = 7'd13;
	localparam logic [6:0] CharLf  = 7'd10;
	localparam logic [6:0] CharPad = 7'd61;

	// padding codes of a group
	localparam logic [1:0] PadNone = 2'd0;
	localparam logic [1:0] PadOne  = 2'd1;
	localparam logic [1:0] PadTwo  = 2'd2;

	// job queue geometry
	localparam int QueueDepth = 2;
	localparam int QueuePtrW  = 1;
	localparam int QueueCntW  = 2;

	// one group of characters to emit
	typedef struct packed {
		logic [3:0][5:0] sext;  // sext[0] is the first character
		logic [1:0]      pad;   // number of trailing '=' characters
		logic            crlf;  // line break follows the group
		logic            fin;   // group closes the message
	} job_t;

	// queue status seen by the front and the back
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// standard alphabet lookup
	function automatic logic [6:0] sym(input logic [5:0] six);
		logic [6:0] code;
		code = 7'd0;
		if (six < 6'd26) begin
			code = 7'd65 + {1'b0, six};
		end else if (six < 6'd52) begin
			code = 7'd97 + {1'b0, six} - 7'd26;
		end else if (six < 6'd62) begin
			code = 7'd48 + {1'b0, six} - 7'd52;
		end else if (six == 6'd62) begin
			code = 7'd43;
		end else begin
			code = 7'd47;
		end
		return code;
	endfunction

endpackage

// ----- rtl/core/b64e_front.sv -----
// front end: collects bytes into groups and turns each group into a job
// depends on b64e_pkg
module b64e_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     data_byte,
	input  logic                           final_byte,
	input  logic                           wrap_enable,
	input  logic [b64e_pkg::LineCountW-1:0] line_groups,
	input  b64e_pkg::q_status_t            q_status,
	output logic                           push,
	output b64e_pkg::job_t                 push_job
);

	typedef enum logic [1:0] {
		PH_EMPTY = 2'd0,
		PH_ONE   = 2'd1,
		PH_TWO   = 2'd2
	} phase_t;

	phase_t                          phase_q;
	logic [15:0]                     held_q;
	logic [b64e_pkg::LineCountW-1:0] line_count_q;

	logic                            accept;
	logic [7:0]                      b0;
	logic [7:0]                      b1;
	logic [b64e_pkg::LineCountW-1:0] lc_inc;
	logic                            brk;

	assign in_stall = q_status.full;
	assign accept   = in_valid && !in_stall;
	assign b0       = held_q[15:8];
	assign b1       = held_q[7:0];
	assign lc_inc   = line_count_q + 6'd1;
	assign brk      = wrap_enable && (lc_inc >= line_groups);

	// classify the byte and build the job for a finished group
	always_comb begin
		push_job      = '0;
		push_job.fin  = final_byte;
		push          = 1'b0;
		case (phase_q)
			PH_TWO: begin
				push_job.sext[0] = b0[7:2];
				push_job.sext[1] = {b0[1:0], b1[7:4]};
				push_job.sext[2] = {b1[3:0], data_byte[7:6]};
				push_job.sext[3] = data_byte[5:0];
				push_job.pad     = b64e_pkg::PadNone;
				push_job.crlf    = brk;
				push             = accept;
			end
			PH_ONE: begin
				push_job.sext[0] = b0[7:2];
				push_job.sext[1] = {b0[1:0], data_byte[7:4]};
				push_job.sext[2] = {data_byte[3:0], 2'b00};
				push_job.pad     = b64e_pkg::PadOne;
				push             = accept && final_byte;
			end
			default: begin
				push_job.sext[0] = data_byte[7:2];
				push_job.sext[1] = {data_byte[1:0], 4'b0000};
				push_job.pad     = b64e_pkg::PadTwo;
				push             = accept && final_byte;
			end
		endcase
	end

	// group collection state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_EMPTY;
			held_q       <= '0;
			line_count_q <= '0;
		end else if (accept) begin
			if (final_byte) begin
				phase_q      <= PH_EMPTY;
				held_q       <= '0;
				line_count_q <= '0;
			end else begin
				case (phase_q)
					PH_TWO: begin
						phase_q      <= PH_EMPTY;
						held_q       <= '0;
						line_count_q <= brk ? '0 : lc_inc;
					end
					PH_ONE: begin
						phase_q <= PH_TWO;
						held_q  <= {b0, data_byte};
					end
					default: begin
						phase_q <= PH_ONE;
						held_q  <= {data_byte, 8'h00};
					end
				endcase
			end
		end
	end

	// a job is only built when the queue has room
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("front pushed into a full queue");

	// held bytes clear whenever no byte is pending
	a_held_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_EMPTY) |-> (held_q == 16'h0000))
		else $error("stale held bytes with empty phase");

	// a line break only appears when wrapping is on
	a_crlf_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_job.crlf) |-> (wrap_enable && phase_q == PH_TWO))
		else $error("line break without wrapping or full group");

endmodule

// ----- rtl/core/b64e_queue.sv -----
// short job queue between the front end and the character back end
// depends on b64e_pkg
module b64e_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  b64e_pkg::job_t      push_job,
	input  logic                pop,
	output b64e_pkg::job_t      head_job,
	output b64e_pkg::q_status_t q_status
);

	b64e_pkg::job_t                 slot_q [b64e_pkg::QueueDepth];
	logic [b64e_pkg::QueuePtrW-1:0] wr_ptr_q;
	logic [b64e_pkg::QueuePtrW-1:0] rd_ptr_q;
	logic [b64e_pkg::QueueCntW-1:0] count_q;

	assign head_job       = slot_q[rd_ptr_q];
	assign q_status.full  = (count_q == b64e_pkg::QueueCntW'(b64e_pkg::QueueDepth));
	assign q_status.empty = (count_q == '0);

	// job storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// fill count never exceeds the depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= b64e_pkg::QueueCntW'(b64e_pkg::QueueDepth))
		else $error("queue count out of range");

	// no pop from an empty queue
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("pop from empty queue");

	// pointers meet whenever the queue is empty
	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.empty |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers out of step");

endmodule

// ----- rtl/core/b64e_back.sv -----
// back end: while out_stall is low, spells each job out one character per cycle into an output register
// depends on b64e_pkg
module b64e_back (
	input  logic                clk,
	input  logic                arst_n,
	input  b64e_pkg::job_t      head_job,
	input  b64e_pkg::q_status_t q_status,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [6:0]          out_char,
	output logic                run_last,
	output logic                message_end
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [6:0] out_char_q;
	logic       run_last_q;
	logic       message_end_q;

	logic       advance;
	logic       is_pad;
	logic       last;
	logic [6:0] next_char;

	assign advance = !out_valid_q || !out_stall;
	assign is_pad  = ((idx_q == 3'd3) && (head_job.pad != b64e_pkg::PadNone))
	              || ((idx_q == 3'd2) && (head_job.pad == b64e_pkg::PadTwo));
	assign last    = head_job.crlf ? (idx_q == 3'd5) : (idx_q == 3'd3);
	assign pop     = advance && !q_status.empty && last;

	// character of the current position
	always_comb begin
		case (idx_q)
			3'd4:    next_char = b64e_pkg::CharCr;
			3'd5:    next_char = b64e_pkg::CharLf;
			default: next_char = is_pad ? b64e_pkg::CharPad
			                            : b64e_pkg::sym(head_job.sext[idx_q[1:0]]);
		endcase
	end

	// position counter and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= !q_status.empty;
			if (!q_status.empty) begin
				idx_q <= last ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (advance && !q_status.empty) begin
			out_char_q    <= next_char;
			run_last_q    <= last;
			message_end_q <= last && head_job.fin;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_char    = out_char_q;
	assign run_last    = run_last_q;
	assign message_end = message_end_q;

	// the position never passes the end of a group with its break
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= 3'd5)
		else $error("character position out of range");

	// end of message always closes the run of the input
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && message_end_q) |-> run_last_q)
		else $error("message end without run end");

	// a job is retired exactly when its final character is loaded
	a_pop_resets: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (idx_q == 3'd0))
		else $error("position not rewound after job");

endmodule

// ----- rtl/core/base64_stream_encoder.sv -----
// Base64 stream encoder, standard alphabet, optional CR LF line wrapping.
// A byte transaction is taken in any cycle in which the two-entry job queue has room; the
// character output runs at one character per cycle while out_stall is low, so a three-byte
// group gives four characters (six with a line break) and the sustained input rate is set
// by that one-character-per-cycle output register. The first character of a group passes
// through a queue slot and the output register after the byte that completes it.
// Configuration writes are always ready and are meant for idle periods. Depends on b64e_pkg,
// b64e_front, b64e_queue and b64e_back.
module base64_stream_encoder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   data_byte,
	input  logic                         final_byte,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [6:0]                   out_char,
	output logic                         run_last,
	output logic                         message_end,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [b64e_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [b64e_pkg::CfgDataW-1:0] cfg_data
);

	logic                            wrap_enable_q;
	logic [b64e_pkg::LineCountW-1:0] line_groups_q;

	logic                            push;
	logic                            pop;
	b64e_pkg::job_t                  push_job;
	b64e_pkg::job_t                  head_job;
	b64e_pkg::q_status_t             q_status;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_enable_q <= b64e_pkg::WrapEnableRst;
			line_groups_q <= b64e_pkg::LineGroupsRst;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				b64e_pkg::RegWrapEnable: wrap_enable_q <= cfg_data[0];
				b64e_pkg::RegLineGroups: line_groups_q <= cfg_data[b64e_pkg::LineCountW-1:0];
				default: ;
			endcase
		end
	end

	b64e_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.final_byte  (final_byte),
		.wrap_enable (wrap_enable_q),
		.line_groups (line_groups_q),
		.q_status    (q_status),
		.push        (push),
		.push_job    (push_job)
	);

	b64e_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.q_status (q_status)
	);

	b64e_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_job    (head_job),
		.q_status    (q_status),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_char    (out_char),
		.run_last    (run_last),
		.message_end (message_end)
	);

endmodule
